/* hw/rtl/blc_pkg.sv */
`default_nettype none
package blc_pkg;

  localparam int COLOR_W   = 24;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = COLOR_W;

  localparam logic [LEVEL_W-1:0] STEP_SIZE = 8'd5;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_COLOR = 2'd0,
    REG_STEP_DELAY = 2'd1,
    REG_MAX_LEVEL  = 2'd2,
    REG_MIN_LEVEL  = 2'd3
  } cfg_reg_t;

  localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 24'h300030;
  localparam logic [LEVEL_W-1:0] STEP_DELAY_RST = 8'd10;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 8'd255;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 8'd0;

  // exact x / 255 for any product of two 8-bit values (x up to 255 * 255): (x + (x >> 8) + 1) >> 8
  function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] x);
    logic [2*LEVEL_W:0] s;
    s = {1'b0, x} + {{(LEVEL_W+1){1'b0}}, x[2*LEVEL_W-1:LEVEL_W]} + {{(2*LEVEL_W){1'b0}}, 1'b1};
    return s[2*LEVEL_W-1:LEVEL_W];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/blc_if.sv */
`default_nettype none
interface blc_in_if;
  import blc_pkg::*;
  logic valid;
  logic ready;
  logic enable;
  modport source (output valid, output enable, input ready);
  modport sink (input valid, input enable, output ready);
endinterface

interface blc_out_if;
  import blc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] rgb_out;
  logic [COLOR_W-1:0] grb_word;
  logic [LEVEL_W-1:0] level_used;
  modport source (output valid, output rgb_out, output grb_word, output level_used,
                  input ready);
  modport sink (input valid, input rgb_out, input grb_word, input level_used,
                output ready);
endinterface
`default_nettype wire

/* hw/rtl/blc_scale.sv */
`default_nettype none
module blc_scale (
  input  wire logic [blc_pkg::COLOR_W-1:0] color,
  input  wire logic [blc_pkg::LEVEL_W-1:0] level,
  output logic [blc_pkg::COLOR_W-1:0]      rgb,
  output logic [blc_pkg::COLOR_W-1:0]      grb
);
  import blc_pkg::*;

  logic [2*LEVEL_W-1:0] prod_r, prod_g, prod_b;
  logic [LEVEL_W-1:0]   r, g, b;

  // one 8x8 product per component, then divide by full scale
  always_comb begin
    prod_r = color[3*LEVEL_W-1:2*LEVEL_W] * level;
    prod_g = color[2*LEVEL_W-1:LEVEL_W] * level;
    prod_b = color[LEVEL_W-1:0] * level;
    r = div255(prod_r);
    g = div255(prod_g);
    b = div255(prod_b);
    rgb = {r, g, b};
    grb = {g, r, b};
  end

endmodule
`default_nettype wire

/* hw/rtl/breathing_led_color_generator.sv */
`default_nettype none
// One breathing LED channel. Each input word carries one tick; a tick with
// enable set yields one result word holding the base color scaled per
// component by the current brightness (c * level / 255, truncated), as RGB
// and in GRB wire order, plus the level used. The brightness follows a
// triangle ramp in steps of 5 between min_level and max_level, stepping once
// every step_delay + 1 enabled ticks and clamping at the bounds. A tick with
// enable clear is taken but gives nothing and leaves the ramp alone. One tick
// is accepted every clock cycle unless the output stalls; a result passes
// through the ramp snapshot register and the scaling multipliers to the output
// register. The user must write registers through cfg_we/cfg_index/cfg_data
// while no tick is in flight, unchecked; new bounds apply from the next step.
module breathing_led_color_generator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [blc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [blc_pkg::CFG_W-1:0]     cfg_data,
  blc_in_if.sink                             in_ch,
  blc_out_if.source                          out_ch
);
  import blc_pkg::*;

  // configuration registers
  logic [COLOR_W-1:0] base_color;
  logic [LEVEL_W-1:0] step_delay;
  logic [LEVEL_W-1:0] max_level;
  logic [LEVEL_W-1:0] min_level;

  // ramp state
  logic               rising;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] wait_count;
  logic               rising_next;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] wait_count_next;

  // snapshot stage
  logic               s1_valid;
  logic [COLOR_W-1:0] s1_color;
  logic [LEVEL_W-1:0] s1_level;

  // output register
  logic               out_valid;
  logic [COLOR_W-1:0] out_rgb;
  logic [COLOR_W-1:0] out_grb;
  logic [LEVEL_W-1:0] out_level;

  logic               out_free;
  logic               in_ready;
  logic               in_fire;
  logic               tick;
  logic               do_step;
  logic [LEVEL_W:0]   up_sum;
  logic [LEVEL_W-1:0] down_val;
  logic [COLOR_W-1:0] scaled_rgb;
  logic [COLOR_W-1:0] scaled_grb;

  // output register takes a new word when empty or being drained
  assign out_free = !out_valid || out_ch.ready;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_ch.valid && in_ready;
  assign tick     = in_fire && in_ch.enable;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.rgb_out    = out_rgb;
  assign out_ch.grb_word   = out_grb;
  assign out_ch.level_used = out_level;

  // configuration writes, the 2-bit index selects one of the four registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_color <= BASE_COLOR_RST;
      step_delay <= STEP_DELAY_RST;
      max_level  <= MAX_LEVEL_RST;
      min_level  <= MIN_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_COLOR: base_color <= cfg_data;
        REG_STEP_DELAY: step_delay <= cfg_data[LEVEL_W-1:0];
        REG_MAX_LEVEL:  max_level  <= cfg_data[LEVEL_W-1:0];
        REG_MIN_LEVEL:  min_level  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ramp step: up without wrap, down saturating at zero, clamp and turn at bounds
  always_comb begin
    do_step         = wait_count >= step_delay;
    up_sum          = {1'b0, level} + {1'b0, STEP_SIZE};
    down_val        = (level < STEP_SIZE) ? '0 : level - STEP_SIZE;
    level_next      = level;
    rising_next     = rising;
    wait_count_next = wait_count + LEVEL_W'(1);
    if (do_step) begin
      wait_count_next = '0;
      if (rising) begin
        if (up_sum >= {1'b0, max_level}) begin
          level_next  = max_level;
          rising_next = 1'b0;
        end else begin
          level_next = up_sum[LEVEL_W-1:0];
        end
      end else begin
        if (down_val <= min_level) begin
          level_next  = min_level;
          rising_next = 1'b1;
        end else begin
          level_next = down_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      rising     <= 1'b1;
      wait_count <= '0;
    end else if (tick) begin
      level      <= level_next;
      rising     <= rising_next;
      wait_count <= wait_count_next;
    end
  end

  // snapshot of color and level for the word being scaled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_color <= base_color;
      s1_level <= level;
    end
  end

  blc_scale u_scale (
    .color (s1_color),
    .level (s1_level),
    .rgb   (scaled_rgb),
    .grb   (scaled_grb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_rgb   <= scaled_rgb;
      out_grb   <= scaled_grb;
      out_level <= s1_level;
    end
  end

  // a snapshot waiting on a full output register keeps its level
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_level))
    else $error("snapshot lost while output stalled");

  // no step before the delay has run out
  a_no_early_step: assert property (@(posedge clk) disable iff (rst)
    tick && (wait_count < step_delay) |=>
      $stable(level) && (wait_count == $past(wait_count) + LEVEL_W'(1)))
    else $error("ramp stepped before delay expired");

  // zero brightness gives black
  a_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_level == '0) |-> (out_rgb == '0) && (out_grb == '0))
    else $error("nonzero color at zero level");

endmodule
`default_nettype wire
